// ===== hdl/sweep_and_prune_broadphase_macros.svh =====
// assertion macros shared by the checker
`ifndef SWEEP_AND_PRUNE_BROADPHASE_MACROS_SVH
`define SWEEP_AND_PRUNE_BROADPHASE_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define SAP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sap check failed");
// next-cycle implication checked outside reset
`define SAP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sap check failed");
`endif

// ===== hdl/sap_pkg.sv =====
package sap_pkg;
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_UPDATE = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_NOT_USE = 2'd2;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_req;
      logic write_box;
      logic set_top;
      logic append;
      logic free_box;
      logic sort_start;
      logic sort_axis;
      logic cmp_step;
      logic delete_step;
      logic delete_start;
      logic pair_step;
      logic pair_start;
      logic respond;
   } sap_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic sort_done;
      logic need_pair;
      logic pair_done;
      logic delete_done;
      logic found_free;
      logic id_ok;
   } sap_stat_type;
endpackage

// ===== hdl/sap_ctrl.sv =====
module sap_ctrl
   import sap_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [1:0]   req_op,
   input  sap_stat_type stat,
   output sap_cmd_type  cmd,
   output logic         busy
);
   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_DECIDE = 10'b0000000010,
      S_SORTX  = 10'b0000000100,
      S_PAIRX  = 10'b0000001000,
      S_SORTY  = 10'b0000010000,
      S_PAIRY  = 10'b0000100000,
      S_DELX   = 10'b0001000000,
      S_DELY   = 10'b0010000000,
      S_RESP   = 10'b0100000000,
      S_SETUP  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] op_ff, op_in;

   // sequencing of one item
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               op_in = req_op;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (op_ff == OP_READ) begin
               state_in = S_RESP;
            end else if (op_ff == OP_ADD && !stat.found_free) begin
               state_in = S_RESP;
            end else if (op_ff != OP_ADD && !stat.id_ok) begin
               state_in = S_RESP;
            end else begin
               cmd.write_box = (op_ff != OP_REMOVE);
               cmd.set_top   = (op_ff == OP_REMOVE);
               cmd.append    = (op_ff == OP_ADD);
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            cmd.sort_start = 1'b1;
            state_in = S_SORTX;
         end
         S_SORTX, S_SORTY: begin
            cmd.sort_axis = (state_ff == S_SORTY);
            if (stat.sort_done) begin
               if (state_ff == S_SORTX) begin
                  cmd.sort_start = 1'b1;
                  cmd.sort_axis  = 1'b1;
                  state_in = S_SORTY;
               end else if (op_ff == OP_REMOVE) begin
                  cmd.delete_start = 1'b1;
                  state_in = S_DELX;
               end else begin
                  state_in = S_RESP;
               end
            end else if (stat.need_pair) begin
               cmd.pair_start = 1'b1;
               state_in = (state_ff == S_SORTX) ? S_PAIRX : S_PAIRY;
            end else begin
               cmd.cmp_step = 1'b1;
            end
         end
         S_PAIRX, S_PAIRY: begin
            cmd.sort_axis = (state_ff == S_PAIRY);
            cmd.pair_step = 1'b1;
            if (stat.pair_done) begin
               state_in = (state_ff == S_PAIRX) ? S_SORTX : S_SORTY;
            end
         end
         S_DELX: begin
            cmd.delete_step = 1'b1;
            if (stat.delete_done) begin
               cmd.delete_start = 1'b1;
               state_in = S_DELY;
            end
         end
         S_DELY: begin
            cmd.delete_step = 1'b1;
            cmd.sort_axis = 1'b1;
            if (stat.delete_done) begin
               cmd.free_box = 1'b1;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff <= op_in;
   end

   assign busy = (state_ff != S_IDLE);
endmodule

// ===== hdl/sap_datapath.sv =====
module sap_datapath
   import sap_pkg::*;
#(
   parameter int MAX_BOXES  = 16,
   parameter int MAX_PAIRS  = 64,
   parameter int COORD_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sap_cmd_type             cmd,
   output sap_stat_type            stat,
   input  logic [1:0]              req_op,
   input  logic [3:0]              req_box_id,
   input  logic signed [15:0]      req_min_x,
   input  logic signed [15:0]      req_min_y,
   input  logic signed [15:0]      req_max_x,
   input  logic signed [15:0]      req_max_y,
   input  logic [5:0]              req_slot,
   output logic                    rsp_valid,
   output logic [3:0]              rsp_assigned_id,
   output logic [1:0]              rsp_status,
   output logic [6:0]              rsp_pair_total,
   output logic [3:0]              rsp_pair_first,
   output logic [3:0]              rsp_pair_second,
   output logic                    rsp_pair_used
);
   localparam int NUM_ENDS = 2 * MAX_BOXES;
   localparam int IW = $clog2(MAX_BOXES);
   localparam int EW = $clog2(NUM_ENDS);
   localparam int LW = $clog2(NUM_ENDS + 1);
   localparam int PW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int CW = $clog2(MAX_PAIRS + 1);
   localparam logic signed [COORD_BITS-1:0] TOP = {1'b0, {(COORD_BITS-1){1'b1}}};

   typedef struct packed {
      logic          is_max;
      logic [IW-1:0] id;
   } endpt_type;

   // box table
   logic signed [COORD_BITS-1:0] mnx_ff [MAX_BOXES];
   logic signed [COORD_BITS-1:0] mny_ff [MAX_BOXES];
   logic signed [COORD_BITS-1:0] mxx_ff [MAX_BOXES];
   logic signed [COORD_BITS-1:0] mxy_ff [MAX_BOXES];
   logic [MAX_BOXES-1:0] used_ff;

   // endpoint lists, one per axis, selected by sort_axis
   endpt_type xl_ff [NUM_ENDS];
   endpt_type yl_ff [NUM_ENDS];
   logic [LW-1:0] len_ff;

   // pair table: slot valid bits in flops, box ids in a memory with registered read
   logic [MAX_PAIRS-1:0] pu_ff;
   logic [2*IW-1:0] pair_mem [MAX_PAIRS];
   logic [2*IW-1:0] pd_ff;
   logic [PW-1:0] pq_ff;
   logic chk_ff;
   logic [CW-1:0] cnt_ff;

   // request latch
   logic [1:0] op_ff;
   logic [3:0] rid_ff;
   logic signed [COORD_BITS-1:0] c0_ff, c1_ff, c2_ff, c3_ff;
   logic [5:0] slot_ff;
   logic [IW-1:0] tgt_ff;
   logic [1:0] st_ff, st_in;

   // sort and scan counters
   logic [LW-1:0] k_ff, i_ff;
   logic [PW:0] p_ff;
   logic [PW:0] free_ff;
   logic found_ff;
   logic add_ff;
   logic [IW-1:0] ka_ff, kb_ff;
   logic [LW-1:0] r_ff, w_ff;

   // free box search
   logic [IW-1:0] free_id;
   logic          free_ok;
   always_comb begin
      free_id = '0;
      free_ok = 1'b0;
      for (int b = MAX_BOXES - 1; b >= 0; b--) begin
         if (!used_ff[b]) begin
            free_id = IW'(b);
            free_ok = 1'b1;
         end
      end
   end

   logic id_in_range;
   assign id_in_range = ({28'd0, rid_ff} < 32'(MAX_BOXES));

   // status of the item being accepted
   logic req_id_ok;
   assign req_id_ok = ({28'd0, req_box_id} < 32'(MAX_BOXES)) && used_ff[req_box_id[IW-1:0]];
   always_comb begin
      st_in = st_ff;
      if (cmd.load_req) begin
         st_in = ST_OK;
         if (req_op == OP_ADD && !free_ok) begin
            st_in = ST_FULL;
         end else if ((req_op == OP_UPDATE || req_op == OP_REMOVE) && !req_id_ok) begin
            st_in = ST_NOT_USE;
         end
      end
   end

   // compare of neighbors at i and i-1
   endpt_type key, prv;
   logic signed [COORD_BITS-1:0] kv, pv;
   logic swap;
   always_comb begin
      key = cmd.sort_axis ? yl_ff[i_ff[EW-1:0]] : xl_ff[i_ff[EW-1:0]];
      prv = cmd.sort_axis ? yl_ff[EW'(i_ff - 1'b1)] : xl_ff[EW'(i_ff - 1'b1)];
      if (cmd.sort_axis) begin
         kv = key.is_max ? mxy_ff[key.id] : mny_ff[key.id];
         pv = prv.is_max ? mxy_ff[prv.id] : mny_ff[prv.id];
      end else begin
         kv = key.is_max ? mxx_ff[key.id] : mnx_ff[key.id];
         pv = prv.is_max ? mxx_ff[prv.id] : mnx_ff[prv.id];
      end
      swap = (kv < pv);
   end

   logic in_inner, k_done;
   assign in_inner = (i_ff != '0);
   assign k_done   = (k_ff >= len_ff);

   logic ovl;
   assign ovl = !(mxx_ff[key.id] < mnx_ff[prv.id]) && !(mnx_ff[key.id] > mxx_ff[prv.id]) &&
                !(mxy_ff[key.id] < mny_ff[prv.id]) && !(mny_ff[key.id] > mxy_ff[prv.id]);

   logic event_add, event_rem;
   assign event_add = !key.is_max && prv.is_max && ovl;
   assign event_rem = key.is_max && !prv.is_max;

   // pair memory read address: scan pointer while scanning, else the read slot
   logic [PW-1:0] prd_addr;
   assign prd_addr = cmd.pair_step ? p_ff[PW-1:0] : slot_ff[PW-1:0];

   assign stat.sort_done   = !in_inner && k_done;
   assign stat.need_pair   = in_inner && swap && (key.id != prv.id) && (event_add || event_rem);
   assign stat.pair_done   = (p_ff == (PW+1)'(MAX_PAIRS)) && !chk_ff;
   assign stat.delete_done = (r_ff >= len_ff);
   assign stat.found_free  = free_ok;
   assign stat.id_ok       = id_in_range && used_ff[rid_ff[IW-1:0]];

   // compare stage of the scan, one slot behind the read
   logic pmatch;
   assign pmatch = chk_ff && pu_ff[pq_ff] &&
                   ((pd_ff[2*IW-1:IW] == ka_ff && pd_ff[IW-1:0] == kb_ff) ||
                    (pd_ff[2*IW-1:IW] == kb_ff && pd_ff[IW-1:0] == ka_ff));

   logic rd_hit;
   assign rd_hit = (op_ff == OP_READ) && ({26'd0, slot_ff} < 32'(MAX_PAIRS)) &&
                   pu_ff[slot_ff[PW-1:0]];

   endpt_type dent;
   assign dent = cmd.sort_axis ? yl_ff[r_ff[EW-1:0]] : xl_ff[r_ff[EW-1:0]];

   always_ff @(posedge clock) begin
      // latch request
      if (cmd.load_req) begin
         op_ff <= req_op; rid_ff <= req_box_id; slot_ff <= req_slot;
         c0_ff <= COORD_BITS'(req_min_x); c1_ff <= COORD_BITS'(req_min_y);
         c2_ff <= COORD_BITS'(req_max_x); c3_ff <= COORD_BITS'(req_max_y);
      end
      // box table writes
      if (cmd.write_box || cmd.set_top) begin
         tgt_ff <= (op_ff == OP_ADD) ? free_id : rid_ff[IW-1:0];
      end
      if (cmd.write_box) begin
         mnx_ff[(op_ff == OP_ADD) ? free_id : rid_ff[IW-1:0]] <= c0_ff;
         mny_ff[(op_ff == OP_ADD) ? free_id : rid_ff[IW-1:0]] <= c1_ff;
         mxx_ff[(op_ff == OP_ADD) ? free_id : rid_ff[IW-1:0]] <= c2_ff;
         mxy_ff[(op_ff == OP_ADD) ? free_id : rid_ff[IW-1:0]] <= c3_ff;
      end
      if (cmd.set_top) begin
         mnx_ff[rid_ff[IW-1:0]] <= TOP; mny_ff[rid_ff[IW-1:0]] <= TOP;
         mxx_ff[rid_ff[IW-1:0]] <= TOP; mxy_ff[rid_ff[IW-1:0]] <= TOP;
      end
      if (cmd.append) begin
         xl_ff[len_ff[EW-1:0]] <= '{is_max: 1'b0, id: free_id};
         xl_ff[EW'(len_ff + 1'b1)] <= '{is_max: 1'b1, id: free_id};
         yl_ff[len_ff[EW-1:0]] <= '{is_max: 1'b0, id: free_id};
         yl_ff[EW'(len_ff + 1'b1)] <= '{is_max: 1'b1, id: free_id};
      end
      // insertion sort, one compare per cycle while no pair scan runs
      if (cmd.sort_start) begin
         k_ff <= LW'(1); i_ff <= '0;
      end else if (cmd.cmp_step) begin
         if (!in_inner) begin
            i_ff <= k_ff;
            k_ff <= k_ff + 1'b1;
         end else if (swap) begin
            if (cmd.sort_axis) begin
               yl_ff[i_ff[EW-1:0]] <= prv; yl_ff[EW'(i_ff - 1'b1)] <= key;
            end else begin
               xl_ff[i_ff[EW-1:0]] <= prv; xl_ff[EW'(i_ff - 1'b1)] <= key;
            end
            i_ff <= i_ff - 1'b1;
         end else begin
            i_ff <= i_ff - 1'b1;
         end
      end
      // pair memory read, registered
      pd_ff <= pair_mem[prd_addr];
      // pair table scan for a swap event
      if (cmd.pair_start) begin
         p_ff <= '0; chk_ff <= 1'b0; found_ff <= 1'b0; free_ff <= (PW+1)'(MAX_PAIRS);
         add_ff <= event_add; ka_ff <= key.id; kb_ff <= prv.id;
      end else if (cmd.pair_step) begin
         if (!stat.pair_done) begin
            if (pmatch) found_ff <= 1'b1;
            if (p_ff < (PW+1)'(MAX_PAIRS)) begin
               if (!pu_ff[p_ff[PW-1:0]] && free_ff == (PW+1)'(MAX_PAIRS)) free_ff <= p_ff;
               pq_ff <= p_ff[PW-1:0];
               p_ff  <= p_ff + 1'b1;
            end
            chk_ff <= (p_ff < (PW+1)'(MAX_PAIRS));
         end else begin
            if (add_ff && !found_ff && free_ff != (PW+1)'(MAX_PAIRS)) begin
               pair_mem[free_ff[PW-1:0]] <= {ka_ff, kb_ff};
            end
            // complete the swap that raised the event
            if (cmd.sort_axis) begin
               yl_ff[i_ff[EW-1:0]] <= prv; yl_ff[EW'(i_ff - 1'b1)] <= key;
            end else begin
               xl_ff[i_ff[EW-1:0]] <= prv; xl_ff[EW'(i_ff - 1'b1)] <= key;
            end
            i_ff <= i_ff - 1'b1;
         end
      end
      // compaction of the removed box's endpoints
      if (cmd.delete_start) begin
         r_ff <= '0; w_ff <= '0;
      end else if (cmd.delete_step && !stat.delete_done) begin
         if (dent.id != tgt_ff) begin
            if (cmd.sort_axis) yl_ff[w_ff[EW-1:0]] <= dent;
            else               xl_ff[w_ff[EW-1:0]] <= dent;
            w_ff <= w_ff + 1'b1;
         end
         r_ff <= r_ff + 1'b1;
      end
      // result
      if (cmd.respond) begin
         rsp_assigned_id <= (op_ff == OP_ADD && st_ff == ST_OK) ? 4'(tgt_ff) : 4'd0;
         rsp_status      <= st_ff;
         rsp_pair_total  <= 7'(cnt_ff);
         rsp_pair_first  <= rd_hit ? 4'(pd_ff[2*IW-1:IW]) : 4'd0;
         rsp_pair_second <= rd_hit ? 4'(pd_ff[IW-1:0]) : 4'd0;
         rsp_pair_used   <= rd_hit;
      end
   end

   // state that is cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0; pu_ff <= '0; cnt_ff <= '0; len_ff <= '0;
         st_ff <= ST_OK; rsp_valid <= 1'b0;
      end else begin
         st_ff     <= st_in;
         rsp_valid <= cmd.respond;
         if (cmd.append) begin
            used_ff[free_id] <= 1'b1;
            len_ff <= len_ff + LW'(2);
         end
         if (cmd.free_box) begin
            used_ff[tgt_ff] <= 1'b0;
            len_ff <= len_ff - LW'(2);
         end
         if (cmd.pair_step) begin
            if (!stat.pair_done) begin
               if (pmatch && !found_ff && !add_ff) pu_ff[pq_ff] <= 1'b0;
            end else if (add_ff && !found_ff && free_ff != (PW+1)'(MAX_PAIRS)) begin
               pu_ff[free_ff[PW-1:0]] <= 1'b1;
               cnt_ff <= cnt_ff + 1'b1;
            end else if (!add_ff && found_ff) begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end
endmodule

// ===== hdl/sweep_and_prune_broadphase.sv =====
// Sweep-and-prune broadphase for up to MAX_BOXES 2D boxes. Pulse start with a
// request while busy is low; one result appears with rsp_valid high for a
// single cycle, and the receiver cannot stall it. An add, update or remove
// that passes its checks runs an insertion sort over each axis list, one
// compare per cycle while no pair scan runs, and every add or remove event
// scans the pair table one slot per cycle with a registered table read. A
// remove also compacts both lists, one entry a cycle. A read does not sort.
module sweep_and_prune_broadphase
   import sap_pkg::*;
#(
   parameter int MAX_BOXES  = 16,
   parameter int MAX_PAIRS  = 64,
   parameter int COORD_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic [3:0]         req_box_id,
   input  logic signed [15:0] req_min_x,
   input  logic signed [15:0] req_min_y,
   input  logic signed [15:0] req_max_x,
   input  logic signed [15:0] req_max_y,
   input  logic [5:0]         req_slot,
   output logic               rsp_valid,
   output logic [3:0]         rsp_assigned_id,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_pair_total,
   output logic [3:0]         rsp_pair_first,
   output logic [3:0]         rsp_pair_second,
   output logic               rsp_pair_used
);
   sap_cmd_type  cmd;
   sap_stat_type stat;

   // sequencer
   sap_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_op(req_op),
      .stat(stat), .cmd(cmd), .busy(busy)
   );

   // tables and sort engine
   sap_datapath #(
      .MAX_BOXES(MAX_BOXES), .MAX_PAIRS(MAX_PAIRS), .COORD_BITS(COORD_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_op(req_op), .req_box_id(req_box_id),
      .req_min_x(req_min_x), .req_min_y(req_min_y),
      .req_max_x(req_max_x), .req_max_y(req_max_y), .req_slot(req_slot),
      .rsp_valid(rsp_valid), .rsp_assigned_id(rsp_assigned_id),
      .rsp_status(rsp_status), .rsp_pair_total(rsp_pair_total),
      .rsp_pair_first(rsp_pair_first), .rsp_pair_second(rsp_pair_second),
      .rsp_pair_used(rsp_pair_used)
   );
endmodule

// ===== hdl/sap_checker.sv =====
`include "sweep_and_prune_broadphase_macros.svh"
module sap_assert (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_status,
   input logic       rsp_pair_used,
   input logic [3:0] rsp_assigned_id
);
   // an accepted item makes the block busy
   `SAP_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   // result comes only once the busy period is over
   `SAP_ASSERT_IMPL(a_rsp_idle, clock, reset, rsp_valid, !busy)
   // status code stays in range
   `SAP_ASSERT_IMPL(a_status, clock, reset, rsp_valid, rsp_status != 2'd3)
   // a failed item reports no pair and no id
   `SAP_ASSERT_IMPL(a_fail, clock, reset, rsp_valid && rsp_status != 2'd0,
      !rsp_pair_used && rsp_assigned_id == 4'd0)
endmodule

bind sweep_and_prune_broadphase sap_assert u_sap_assert (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status),
   .rsp_pair_used(rsp_pair_used), .rsp_assigned_id(rsp_assigned_id)
);
